@@ hw/rtl/iole_pkg.sv @@
// shared types, codes and sizes of the indexed ordered list engine
package iole_pkg;

    localparam int CAPACITY = 64;
    localparam int DATA_W   = 32;
    localparam int CMD_W    = 3;
    localparam int POS_W    = 7;
    localparam int IOC_W    = 7;
    localparam int ST_W     = 2;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

    localparam logic [CMD_W-1:0] CMD_APPEND = 3'd0;
    localparam logic [CMD_W-1:0] CMD_INSERT = 3'd1;
    localparam logic [CMD_W-1:0] CMD_ERASE  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_SET    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_GET    = 3'd4;
    localparam logic [CMD_W-1:0] CMD_FIND   = 3'd5;
    localparam logic [CMD_W-1:0] CMD_LENGTH = 3'd6;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd7;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

    typedef logic [DATA_W-1:0] entry_t;

    typedef struct packed {
        logic [CMD_W-1:0]        cmd;
        logic [POS_W-1:0]        position;
        logic signed [DATA_W-1:0] value;
    } in_item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] read_value;
        logic [IOC_W-1:0]         index_or_count;
        logic                     found;
        logic [ST_W-1:0]          status;
    } out_item_t;

    typedef struct packed {
        logic             exec;
        logic             ok;
        logic [CMD_W-1:0] op;
        logic [CMP_W-1:0] pos;
        entry_t           val;
        logic [CMP_W-1:0] count;
    } cell_ctrl_t;

endpackage

@@ hw/rtl/indexed_ordered_list_engine.sv @@
// top level of the indexed ordered list engine: command control and cell chain
//
//  channel   direction  transfer marked by        payload
//  command   in         start & !busy at clk edge  command (cmd, position, value)
//  result    out        done for one cycle         result (read_value, index_or_count,
//                                                  found, status)
//
// a command is taken into the command registers and sets exec_reg; the cell row
// executes it and sets report_reg; result register and done_reg then load together
// busy is high for the one cycle between acceptance and execution; a new
// command can be taken as soon as busy is low, before done reports the previous result
// all commands, find included, take the same time: every cell compares at once
// reset clears the length and the control flags; entry contents are not cleared
// the receiver cannot stall, results are never held back
module indexed_ordered_list_engine (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  iole_pkg::in_item_t  command,
    output logic                done,
    output iole_pkg::out_item_t result
);
    import iole_pkg::*;

    logic             exec_reg;
    logic             report_reg;
    logic             done_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    logic [CMD_W-1:0] op_reg;
    logic [CMP_W-1:0] pos_reg;
    entry_t           val_reg;
    logic [ST_W-1:0]  status_reg;
    logic [ST_W-1:0]  status_next;
    logic [CNT_W-1:0] len_reg;
    out_item_t        result_reg;
    out_item_t        result_next;

    logic             accept;
    logic [CMP_W-1:0] pos_in;
    logic [CMP_W-1:0] count_ext;
    logic             is_full;
    logic             ok;

    cell_ctrl_t                    cell_ctrl;
    entry_t [CAPACITY-1:0]         entries;
    logic [CAPACITY-1:0]           hits;
    entry_t                        read_data;
    logic [IDX_W-1:0]              first_index;
    logic                          any_hit;

    assign accept    = start && !exec_reg;
    assign pos_in    = CMP_W'(command.position);
    assign count_ext = CMP_W'(count_reg);
    assign is_full   = (count_reg == CNT_W'(CAPACITY));
    assign ok        = (status_reg == ST_OK);

    always_comb
    begin
        status_next = ST_OK;
        case (command.cmd)
            CMD_APPEND:
            begin
                if (is_full)
                    status_next = ST_FULL;
            end
            CMD_INSERT:
            begin
                if (pos_in > count_ext)
                    status_next = ST_RANGE;
                else if (is_full)
                    status_next = ST_FULL;
            end
            CMD_ERASE, CMD_SET, CMD_GET:
            begin
                if (pos_in >= count_ext)
                    status_next = ST_RANGE;
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg     <= command.cmd;
            pos_reg    <= pos_in;
            val_reg    <= entry_t'(command.value);
            status_reg <= status_next;
            len_reg    <= count_reg;
        end
        if (report_reg)
            result_reg <= result_next;
    end

    always_comb
    begin
        count_next = count_reg;
        if (exec_reg)
        begin
            case (op_reg)
                CMD_APPEND, CMD_INSERT:
                begin
                    if (ok)
                        count_next = count_reg + CNT_W'(1);
                end
                CMD_ERASE:
                begin
                    if (ok)
                        count_next = count_reg - CNT_W'(1);
                end
                CMD_CLEAR:
                begin
                    count_next = '0;
                end
                default:
                begin
                    count_next = count_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exec_reg   <= 1'b0;
            report_reg <= 1'b0;
            done_reg   <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            exec_reg   <= accept;
            report_reg <= exec_reg;
            done_reg   <= report_reg;
            count_reg  <= count_next;
        end
    end

    assign cell_ctrl.exec  = exec_reg;
    assign cell_ctrl.ok    = ok;
    assign cell_ctrl.op    = op_reg;
    assign cell_ctrl.pos   = pos_reg;
    assign cell_ctrl.val   = val_reg;
    assign cell_ctrl.count = count_ext;

    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        entry_t left_entry;
        entry_t right_entry;
        if (g == 0)
        begin : g_first
            assign left_entry = '0;
        end
        else
        begin : g_mid_left
            assign left_entry = entries[g-1];
        end
        if (g == CAPACITY - 1)
        begin : g_last
            assign right_entry = entries[g];
        end
        else
        begin : g_mid_right
            assign right_entry = entries[g+1];
        end
        iole_cell u_cell (
            .clk         (clk),
            .ctrl        (cell_ctrl),
            .cell_index  (IDX_W'(g)),
            .left_entry  (left_entry),
            .right_entry (right_entry),
            .entry       (entries[g]),
            .hit         (hits[g])
        );
    end

    iole_collect u_collect (
        .entries     (entries),
        .hits        (hits),
        .read_data   (read_data),
        .first_index (first_index),
        .any_hit     (any_hit)
    );

    always_comb
    begin
        result_next                = '0;
        result_next.status         = status_reg;
        case (op_reg)
            CMD_GET:
            begin
                result_next.read_value = read_data;
            end
            CMD_FIND:
            begin
                result_next.found = any_hit;
                if (any_hit)
                    result_next.index_or_count = IOC_W'(first_index);
            end
            CMD_LENGTH:
            begin
                result_next.index_or_count = IOC_W'(len_reg);
            end
            default:
            begin
                result_next.read_value = '0;
            end
        endcase
    end

    assign busy   = exec_reg;
    assign done   = done_reg;
    assign result = result_reg;

endmodule

@@ hw/rtl/iole_cell.sv @@
// one storage cell of the list chain with shift, write and compare logic
module iole_cell (
    input  logic                 clk,
    input  iole_pkg::cell_ctrl_t ctrl,
    input  logic [iole_pkg::IDX_W-1:0] cell_index,
    input  iole_pkg::entry_t     left_entry,
    input  iole_pkg::entry_t     right_entry,
    output iole_pkg::entry_t     entry,
    output logic                 hit
);
    import iole_pkg::*;

    entry_t           entry_reg;
    entry_t           entry_next;
    logic             hit_reg;
    logic             hit_next;
    logic [CMP_W-1:0] idx;

    assign idx = CMP_W'(cell_index);

    always_comb
    begin
        entry_next = entry_reg;
        hit_next   = hit_reg;
        if (ctrl.exec)
        begin
            hit_next = 1'b0;
            case (ctrl.op)
                CMD_APPEND:
                begin
                    if (ctrl.ok && idx == ctrl.count)
                        entry_next = ctrl.val;
                end
                CMD_INSERT:
                begin
                    if (ctrl.ok && idx == ctrl.pos)
                        entry_next = ctrl.val;
                    else if (ctrl.ok && idx > ctrl.pos)
                        entry_next = left_entry;
                end
                CMD_ERASE:
                begin
                    if (ctrl.ok && idx >= ctrl.pos)
                        entry_next = right_entry;
                end
                CMD_SET:
                begin
                    if (ctrl.ok && idx == ctrl.pos)
                        entry_next = ctrl.val;
                end
                CMD_GET:
                begin
                    hit_next = ctrl.ok && (idx == ctrl.pos);
                end
                CMD_FIND:
                begin
                    hit_next = (entry_reg == ctrl.val) && (idx < ctrl.count);
                end
                default:
                begin
                    hit_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        hit_reg   <= hit_next;
    end

    assign entry = entry_reg;
    assign hit   = hit_reg;

endmodule

@@ hw/rtl/iole_collect.sv @@
// gathers the read value and first matching index from the cell row
module iole_collect (
    input  iole_pkg::entry_t [iole_pkg::CAPACITY-1:0] entries,
    input  logic [iole_pkg::CAPACITY-1:0]             hits,
    output iole_pkg::entry_t                          read_data,
    output logic [iole_pkg::IDX_W-1:0]                first_index,
    output logic                                      any_hit
);
    import iole_pkg::*;

    always_comb
    begin
        read_data = '0;
        for (int i = 0; i < CAPACITY; i++)
            read_data = read_data | (entries[i] & {DATA_W{hits[i]}});
    end

    // lowest set hit wins
    always_comb
    begin
        first_index = '0;
        for (int i = CAPACITY - 1; i >= 0; i--)
        begin
            if (hits[i])
                first_index = IDX_W'(i);
        end
    end

    assign any_hit = |hits;

endmodule

@@ hw/rtl/iole_checker.sv @@
// port-level checks of the indexed ordered list engine and their binding
module iole_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                start,
    input logic                busy,
    input logic                done,
    input iole_pkg::out_item_t result
);
    import iole_pkg::*;

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted command did not raise busy");

    a_busy_single: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> !busy)
        else $error("busy held longer than one cycle");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> ##2 done)
        else $error("no result two cycles after busy");

    a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.status == ST_OK || result.status == ST_RANGE
                  || result.status == ST_FULL))
        else $error("illegal status code");

    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.found |-> result.status == ST_OK && result.read_value == '0)
        else $error("find result with bad status or data");

endmodule

bind indexed_ordered_list_engine iole_checker u_iole_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .done    (done),
    .result  (result)
);

@@ bench/testbench.sv @@
// self-checking testbench of the indexed ordered list engine
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import iole_pkg::*;

    localparam int STALL_LIMIT = 200;
    localparam int DRAIN_CYCLES = 8;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      start = 1'b0;
    logic      busy;
    in_item_t  command = '0;
    logic      done;
    out_item_t result;

    logic signed [DATA_W-1:0] list_entries [0:CAPACITY-1];
    int                       list_count = 0;
    out_item_t                pending_results [$];
    int                       error_count = 0;
    int                       stall_cycles = 0;

    indexed_ordered_list_engine i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .command (command),
        .done    (done),
        .result  (result)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic out_item_t list_apply(in_item_t c);
        out_item_t r;
        int        pos;
        bit        hit;
        r   = '0;
        pos = int'(c.position);
        hit = 1'b0;
        case (c.cmd)
            CMD_APPEND:
            begin
                if (list_count >= CAPACITY)
                    r.status = ST_FULL;
                else
                begin
                    list_entries[list_count] = c.value;
                    list_count++;
                end
            end
            CMD_INSERT:
            begin
                if (pos > list_count)
                    r.status = ST_RANGE;
                else if (list_count >= CAPACITY)
                    r.status = ST_FULL;
                else
                begin
                    for (int i = list_count; i > pos; i--)
                        list_entries[i] = list_entries[i-1];
                    list_entries[pos] = c.value;
                    list_count++;
                end
            end
            CMD_ERASE:
            begin
                if (pos >= list_count)
                    r.status = ST_RANGE;
                else
                begin
                    for (int i = pos; i + 1 < list_count; i++)
                        list_entries[i] = list_entries[i+1];
                    list_count--;
                end
            end
            CMD_SET:
            begin
                if (pos >= list_count)
                    r.status = ST_RANGE;
                else
                    list_entries[pos] = c.value;
            end
            CMD_GET:
            begin
                if (pos >= list_count)
                    r.status = ST_RANGE;
                else
                    r.read_value = list_entries[pos];
            end
            CMD_FIND:
            begin
                for (int i = 0; i < list_count && !hit; i++)
                begin
                    if (list_entries[i] == c.value)
                    begin
                        hit              = 1'b1;
                        r.found          = 1'b1;
                        r.index_or_count = IOC_W'(i);
                    end
                end
            end
            CMD_LENGTH:
                r.index_or_count = IOC_W'(list_count);
            default:
                list_count = 0;
        endcase
        return r;
    endfunction

    function automatic in_item_t make_command(logic [CMD_W-1:0] cmd, int pos,
                                              logic signed [DATA_W-1:0] value);
        in_item_t c;
        c.cmd      = cmd;
        c.position = POS_W'(pos);
        c.value    = value;
        return c;
    endfunction

    function automatic logic signed [DATA_W-1:0] random_value();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5)
            return DATA_W'($urandom_range(0, 7)) - 32'sd4;
        else if (r == 5)
            return (($urandom_range(0, 1) == 0) ? 32'sh7fffffff : 32'sh80000000);
        return $urandom;
    endfunction

    function automatic int random_position();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7)
            return $urandom_range(0, list_count);
        else if (r == 7)
            return (list_count + 1) % (1 << POS_W);
        return $urandom_range(0, (1 << POS_W) - 1);
    endfunction

    function automatic in_item_t random_command(bit grow);
        in_item_t c;
        int       r;
        int       app_end;
        int       ins_end;
        int       era_end;
        r       = $urandom_range(0, 99);
        app_end = grow ? 30 : 8;
        ins_end = grow ? 50 : 14;
        era_end = grow ? 58 : 50;
        if (r < 2)
            c.cmd = CMD_CLEAR;
        else if (r < app_end)
            c.cmd = CMD_APPEND;
        else if (r < ins_end)
            c.cmd = CMD_INSERT;
        else if (r < era_end)
            c.cmd = CMD_ERASE;
        else if (r < era_end + 12)
            c.cmd = CMD_SET;
        else if (r < era_end + 24)
            c.cmd = CMD_GET;
        else if (r < era_end + 36)
            c.cmd = CMD_FIND;
        else
            c.cmd = CMD_LENGTH;
        c.position = POS_W'(random_position());
        c.value    = random_value();
        return c;
    endfunction

    function automatic int idle_gap(bit idle_on);
        if (idle_on && $urandom_range(0, 3) == 0)
            return $urandom_range(1, 4);
        return 0;
    endfunction

    // start stays high across back-to-back transfers
    task automatic send_command(in_item_t item, int gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start   <= 1'b1;
        command <= item;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_results.push_back(list_apply(item));
    endtask

    task automatic send_directed(logic [CMD_W-1:0] cmd, int pos,
                                 logic signed [DATA_W-1:0] value);
        send_command(make_command(cmd, pos, value), idle_gap(1'b1));
    endtask

    task automatic test_empty_list();
        send_directed(CMD_GET, 0, 0);
        send_directed(CMD_ERASE, 0, 0);
        send_directed(CMD_SET, 0, 32'sd9);
        send_directed(CMD_FIND, 0, 0);
        send_directed(CMD_LENGTH, 0, 0);
        send_directed(CMD_INSERT, 1, 32'sd3);
        send_directed(CMD_CLEAR, 0, 0);
    endtask

    task automatic test_edit_ops();
        send_directed(CMD_APPEND, 0, 32'sh7fffffff);
        send_directed(CMD_APPEND, 0, 32'sh80000000);
        send_directed(CMD_APPEND, 0, 0);
        send_directed(CMD_APPEND, 0, -32'sd1);
        send_directed(CMD_INSERT, 0, 32'sd5);
        send_directed(CMD_INSERT, 5, 32'sd5);
        send_directed(CMD_INSERT, 7, 32'sd6);
        send_directed(CMD_GET, 0, 0);
        send_directed(CMD_GET, 5, 0);
        send_directed(CMD_GET, 127, 0);
        send_directed(CMD_SET, 2, 32'sh55555555);
        send_directed(CMD_FIND, 0, 32'sd5);
        send_directed(CMD_FIND, 0, 32'sd12345);
        send_directed(CMD_ERASE, 0, 0);
        send_directed(CMD_ERASE, 4, 0);
        send_directed(CMD_ERASE, 4, 0);
        send_directed(CMD_LENGTH, 0, 0);
        send_directed(CMD_CLEAR, 99, 32'sh2aaaaaaa);
        send_directed(CMD_LENGTH, 0, 0);
        send_directed(CMD_GET, 0, 0);
    endtask

    task automatic test_full_list();
        send_directed(CMD_CLEAR, 0, 0);
        while (list_count < CAPACITY)
            send_directed(CMD_APPEND, 0, random_value());
        send_directed(CMD_APPEND, 0, 32'sd1);
        send_directed(CMD_INSERT, CAPACITY, 32'sd1);
        send_directed(CMD_INSERT, CAPACITY + 1, 32'sd1);
        send_directed(CMD_INSERT, 0, 32'sd1);
        send_directed(CMD_GET, CAPACITY - 1, 0);
        send_directed(CMD_FIND, 0, list_entries[CAPACITY-1]);
        send_directed(CMD_LENGTH, 0, 0);
        send_directed(CMD_ERASE, 0, 0);
        send_directed(CMD_INSERT, CAPACITY - 1, 32'sh7fffffff);
        send_directed(CMD_ERASE, CAPACITY - 1, 0);
    endtask

    task automatic test_random_mix(int count, bit idle_allowed);
        bit grow;
        bit idle_on;
        grow    = 1'b1;
        idle_on = idle_allowed;
        for (int n = 0; n < count; n++)
        begin
            if (list_count >= CAPACITY)
                grow = 1'b0;
            else if (list_count <= 2)
                grow = 1'b1;
            if (n % 50 == 0)
                idle_on = idle_allowed && ($urandom_range(0, 2) != 0);
            send_command(random_command(grow), idle_gap(idle_on));
        end
    endtask

    task automatic finish_run();
        start <= 1'b0;
        while (pending_results.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    endtask

    always @(posedge clk)
    begin
        out_item_t exp_r;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result transfer with nothing expected");
                error_count++;
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (result.read_value !== exp_r.read_value)
                begin
                    $error("read_value: expected %0d, got %0d",
                           exp_r.read_value, result.read_value);
                    error_count++;
                end
                if (result.index_or_count !== exp_r.index_or_count)
                begin
                    $error("index_or_count: expected %0d, got %0d",
                           exp_r.index_or_count, result.index_or_count);
                    error_count++;
                end
                if (result.found !== exp_r.found)
                begin
                    $error("found: expected %0d, got %0d", exp_r.found, result.found);
                    error_count++;
                end
                if (result.status !== exp_r.status)
                begin
                    $error("status: expected %0d, got %0d", exp_r.status, result.status);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);
        test_empty_list();
        test_edit_ops();
        test_full_list();
        test_random_mix(650, 1'b1);
        test_random_mix(100, 1'b0);
        finish_run();
    end

endmodule
